// File: src/dpa_pkg.sv
// Shared types and constants for the data-processing ALU with shifter.
// Used by dpa_shifter, dpa_alu and data_processing_alu_with_shifter.
package dpa_pkg;

    localparam int WORD_W  = 32;
    localparam int FIELD_W = 12;
    localparam int OPC_W   = 4;
    localparam int SHAMT_W = 5;

    // opcode numbering
    localparam logic [OPC_W-1:0] OPC_AND = 4'd0;
    localparam logic [OPC_W-1:0] OPC_EOR = 4'd1;
    localparam logic [OPC_W-1:0] OPC_SUB = 4'd2;
    localparam logic [OPC_W-1:0] OPC_RSB = 4'd3;
    localparam logic [OPC_W-1:0] OPC_ADD = 4'd4;
    localparam logic [OPC_W-1:0] OPC_TST = 4'd8;
    localparam logic [OPC_W-1:0] OPC_TEQ = 4'd9;
    localparam logic [OPC_W-1:0] OPC_CMP = 4'd10;
    localparam logic [OPC_W-1:0] OPC_ORR = 4'd12;
    localparam logic [OPC_W-1:0] OPC_MOV = 4'd13;

    // shift types
    localparam logic [1:0] SHT_LSL = 2'd0;
    localparam logic [1:0] SHT_LSR = 2'd1;
    localparam logic [1:0] SHT_ASR = 2'd2;
    localparam logic [1:0] SHT_ROR = 2'd3;

    // second operand and shifter carry
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              carry;
    } op2_t;

    // one result word
    typedef struct packed {
        logic [WORD_W-1:0] alu_result;
        logic              write_dest;
        logic              flags_update;
        logic              flag_negative;
        logic              flag_zero;
        logic              flag_carry;
    } result_t;

endpackage

// File: src/dpa_shifter.sv
// Operand-2 builder: rotated immediate or constant barrel shift of rm.
// Depends on dpa_pkg.
module dpa_shifter
    import dpa_pkg::*;
(
    input  logic               is_immediate,
    input  logic [FIELD_W-1:0] operand_field,
    input  logic [WORD_W-1:0]  shifted_value,
    output op2_t               op2
);

    logic [SHAMT_W-1:0]  amt;
    logic [1:0]          sh_type;
    logic [SHAMT_W-1:0]  rot;
    logic [WORD_W-1:0]   imm_word;
    logic [2*WORD_W-1:0] imm_dbl;
    logic [2*WORD_W-1:0] rm_dbl;
    logic [WORD_W:0]     lsl_ext;
    logic [WORD_W:0]     lsr_ext;
    logic [WORD_W:0]     asr_ext;
    logic [WORD_W-1:0]   ror_val;

    assign amt      = operand_field[11:7];
    assign sh_type  = operand_field[6:5];
    assign rot      = {operand_field[11:8], 1'b0};
    assign imm_word = {{(WORD_W-8){1'b0}}, operand_field[7:0]};
    assign imm_dbl  = {imm_word, imm_word} >> rot;
    assign rm_dbl   = {shifted_value, shifted_value} >> amt;

    // extra bit catches the last bit shifted out; zero amount leaves it clear
    assign lsl_ext = {1'b0, shifted_value} << amt;
    assign lsr_ext = {shifted_value, 1'b0} >> amt;
    assign asr_ext = $unsigned($signed({shifted_value, 1'b0}) >>> amt);
    assign ror_val = rm_dbl[WORD_W-1:0];

    always_comb
    begin
        op2.value = '0;
        op2.carry = 1'b0;
        if (is_immediate)
        begin
            op2.value = imm_dbl[WORD_W-1:0];
        end
        else if (!operand_field[4])
        begin
            case (sh_type)
                SHT_LSL:
                begin
                    op2.value = lsl_ext[WORD_W-1:0];
                    op2.carry = lsl_ext[WORD_W];
                end
                SHT_LSR:
                begin
                    op2.value = lsr_ext[WORD_W:1];
                    op2.carry = lsr_ext[0];
                end
                SHT_ASR:
                begin
                    op2.value = asr_ext[WORD_W:1];
                    op2.carry = (amt == '0) ? 1'b0 : asr_ext[0];
                end
                SHT_ROR:
                begin
                    op2.value = ror_val;
                    op2.carry = (amt == '0) ? 1'b0 : ror_val[WORD_W-1];
                end
                default:
                begin
                    op2.value = '0;
                    op2.carry = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: src/dpa_alu.sv
// Data-processing ALU: logic, add/subtract and N, Z, C flag generation.
// Depends on dpa_pkg.
module dpa_alu
    import dpa_pkg::*;
(
    input  logic [OPC_W-1:0]  opcode,
    input  logic              set_flags,
    input  logic [WORD_W-1:0] rn_value,
    input  op2_t              op2,
    output result_t           res
);

    logic [WORD_W:0]   sum_add;
    logic [WORD_W:0]   sum_sub;
    logic [WORD_W:0]   sum_rsb;
    logic [WORD_W-1:0] r;
    logic              c;
    logic              known;
    logic              wr;

    assign sum_add = {1'b0, rn_value} + {1'b0, op2.value};
    // carry out of a + ~b + 1 is the no-borrow flag
    assign sum_sub = {1'b0, rn_value} + {1'b0, ~op2.value} + {{WORD_W{1'b0}}, 1'b1};
    assign sum_rsb = {1'b0, op2.value} + {1'b0, ~rn_value} + {{WORD_W{1'b0}}, 1'b1};

    always_comb
    begin
        r     = '0;
        c     = 1'b0;
        known = 1'b1;
        wr    = 1'b0;
        case (opcode)
            OPC_AND: begin r = rn_value & op2.value; c = op2.carry; wr = 1'b1; end
            OPC_EOR: begin r = rn_value ^ op2.value; c = op2.carry; wr = 1'b1; end
            OPC_SUB: begin r = sum_sub[WORD_W-1:0]; c = sum_sub[WORD_W]; wr = 1'b1; end
            OPC_RSB: begin r = sum_rsb[WORD_W-1:0]; c = sum_rsb[WORD_W]; wr = 1'b1; end
            OPC_ADD: begin r = sum_add[WORD_W-1:0]; c = sum_add[WORD_W]; wr = 1'b1; end
            OPC_TST: begin r = rn_value & op2.value; c = op2.carry; end
            OPC_TEQ: begin r = rn_value ^ op2.value; c = op2.carry; end
            OPC_CMP: begin r = sum_sub[WORD_W-1:0]; c = sum_sub[WORD_W]; end
            OPC_ORR: begin r = rn_value | op2.value; c = op2.carry; wr = 1'b1; end
            OPC_MOV: begin r = op2.value; c = op2.carry; wr = 1'b1; end
            default: known = 1'b0;
        endcase
    end

    always_comb
    begin
        res.alu_result    = r;
        res.write_dest    = wr;
        res.flags_update  = known & set_flags;
        res.flag_negative = known & set_flags & r[WORD_W-1];
        res.flag_zero     = known & set_flags & (r == '0);
        res.flag_carry    = known & set_flags & c;
    end

endmodule

// File: src/data_processing_alu_with_shifter.sv
// Top level of the data-processing ALU: input register, shifter and ALU, result register.
// Depends on dpa_pkg, dpa_shifter and dpa_alu.
//
// Usage:
//   Input channel in_valid / in_stall carries one instruction word: opcode,
//   set_flags, is_immediate, operand_field, rn_value and shifted_value.
//   A word is taken at a clock edge with in_valid high and in_stall low.
//   Output channel out_valid / out_stall carries one result word per input
//   word: alu_result, write_dest, flags_update and the N, Z, C flags.
//   A taken word passes through the input register, then through the shifter
//   and ALU into the result register, which drives the outputs.
//   Throughput: one word per cycle, sustained, while out_stall stays low;
//   the single pass through shifter and ALU sets the figure.
//   When out_stall holds a result, the input register still loads one more
//   word; in_stall rises only when both registers are full.
//   Reset (rst_n low, asynchronous) empties both registers; out_valid and
//   in_stall go low. The block has no other state.
module data_processing_alu_with_shifter
    import dpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OPC_W-1:0]   opcode,
    input  logic               set_flags,
    input  logic               is_immediate,
    input  logic [FIELD_W-1:0] operand_field,
    input  logic [WORD_W-1:0]  rn_value,
    input  logic [WORD_W-1:0]  shifted_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [WORD_W-1:0]  alu_result,
    output logic               write_dest,
    output logic               flags_update,
    output logic               flag_negative,
    output logic               flag_zero,
    output logic               flag_carry
);

    logic               s1_valid_reg;
    logic [OPC_W-1:0]   opc_reg;
    logic               sflag_reg;
    logic               imm_reg;
    logic [FIELD_W-1:0] field_reg;
    logic [WORD_W-1:0]  rn_reg;
    logic [WORD_W-1:0]  rm_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            res_reg;
    result_t            res_next;
    op2_t               op2;
    logic               out_move;
    logic               s1_load;

    assign out_move = !(out_valid_reg && out_stall);
    assign s1_load  = !s1_valid_reg || out_move;
    assign in_stall = !s1_load;
    assign out_valid_next = out_move ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            opc_reg   <= opcode;
            sflag_reg <= set_flags;
            imm_reg   <= is_immediate;
            field_reg <= operand_field;
            rn_reg    <= rn_value;
            rm_reg    <= shifted_value;
        end
        if (out_move && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    dpa_shifter u_shifter
    (
        .is_immediate  (imm_reg),
        .operand_field (field_reg),
        .shifted_value (rm_reg),
        .op2           (op2)
    );

    dpa_alu u_alu
    (
        .opcode    (opc_reg),
        .set_flags (sflag_reg),
        .rn_value  (rn_reg),
        .op2       (op2),
        .res       (res_next)
    );

    assign out_valid     = out_valid_reg;
    assign alu_result    = res_reg.alu_result;
    assign write_dest    = res_reg.write_dest;
    assign flags_update  = res_reg.flags_update;
    assign flag_negative = res_reg.flag_negative;
    assign flag_zero     = res_reg.flag_zero;
    assign flag_carry    = res_reg.flag_carry;

    // stall only with a word held in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall raised with empty input register");

    // a held word moves on once the result register frees up
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_move) |=> out_valid)
        else $error("input word lost on advance");

    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !flags_update) |-> (!flag_negative && !flag_zero && !flag_carry))
        else $error("flags set without flags_update");

    a_flags_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && flags_update) |->
            (flag_zero == (alu_result == '0) && flag_negative == alu_result[WORD_W-1]))
        else $error("N or Z flag disagrees with result");

endmodule
